// File: src/lfob_pkg.sv
package lfob_pkg;

	localparam int NUM_OSC_DEF          = 4;
	localparam int PHASE_BITS_DEF       = 24;
	localparam int SINE_TABLE_DEPTH_DEF = 256;

	localparam int CFG_ADDR_W = 3;
	localparam int CFG_DATA_W = 64;

	localparam int RATE_W   = 64;
	localparam int DEPTHS_W = 52;
	localparam int SHAPES_W = 12;
	localparam int OFFSET_W = 64;
	localparam int MASK_W   = 4;
	localparam int SYNC_W   = 16;

	localparam int INC_W    = 16;
	localparam int DEPTH_W  = 13;
	localparam int SHAPE_W  = 3;
	localparam int OFF_W    = 16;
	localparam int SAMPLE_W = 13;
	localparam int LEVEL_W  = 16;
	localparam int INDEX_W  = 2;

	localparam int P_W    = 16;
	localparam int SINE_W = 17;
	localparam int RAW_W  = 18;
	localparam int MB_W   = 14;
	localparam int PROD_W = RAW_W + MB_W;

	localparam logic [P_W-1:0] RAND_WINDOW = 16'd66;

	localparam logic [31:0] SEED_INIT [4] = '{
		32'h12345678, 32'h9E3779B9, 32'h2545F491, 32'h6C8E9CF5
	};

	typedef enum logic [CFG_ADDR_W-1:0] {
		REG_RATE_INCREMENTS = 3'd0,
		REG_DEPTHS          = 3'd1,
		REG_SHAPE_SELECTS   = 3'd2,
		REG_PHASE_OFFSETS   = 3'd3,
		REG_SYNC_MASK       = 3'd4,
		REG_SYNC_INCREMENT  = 3'd5
	} cfg_reg_t;

	typedef enum logic [SHAPE_W-1:0] {
		SHAPE_SINE     = 3'd0,
		SHAPE_SQUARE   = 3'd1,
		SHAPE_TRIANGLE = 3'd2,
		SHAPE_RAMPUP   = 3'd3,
		SHAPE_RAMPDOWN = 3'd4,
		SHAPE_RANDOM   = 3'd5
	} shape_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL_INC,
		ST_ACC,
		ST_PHASE,
		ST_ROM,
		ST_RAW,
		ST_MUL_DEPTH,
		ST_EMIT
	} state_t;

endpackage

// File: src/lfo_bank_waveform_generator_top.sv
// Bank of up to four low-frequency oscillators advanced once per audio block. Each input word
// carries the block length in samples; the block then emits one signed Q1.15 level per
// oscillator, oscillator 0 first, with tlast on the last one and the oscillator number in tuser.
// One multiplier is shared by the phase advance and the depth scaling, and a sequencer walks
// the oscillators one after another; s_axis_tready is high only between items, so a new block
// length is not taken before the last item is done. Configuration is to be written while the
// block is idle, which the block itself does not enforce; it takes effect on the next block.
module lfo_bank_waveform_generator_top #(
	parameter int NUM_OSC          = lfob_pkg::NUM_OSC_DEF,
	parameter int PHASE_BITS       = lfob_pkg::PHASE_BITS_DEF,
	parameter int SINE_TABLE_DEPTH = lfob_pkg::SINE_TABLE_DEPTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wr_en,
	input  logic [lfob_pkg::CFG_ADDR_W-1:0] cfg_addr,
	input  logic [lfob_pkg::CFG_DATA_W-1:0] cfg_wdata,
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	input  logic [15:0]                   s_axis_tdata,  // [12:0] block_samples
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	output logic [15:0]                   m_axis_tdata,  // [15:0] level
	output logic [1:0]                    m_axis_tuser,  // [1:0] osc_index
	output logic                          m_axis_tlast
);
	import lfob_pkg::*;

	localparam int OscW      = (NUM_OSC > 1) ? $clog2(NUM_OSC) : 1;
	localparam int AddrW     = $clog2(SINE_TABLE_DEPTH + 1);
	localparam int IdxProdW  = 14 + AddrW;

	logic [RATE_W-1:0]   rate_increments_q;
	logic [DEPTHS_W-1:0] depths_q;
	logic [SHAPES_W-1:0] shape_selects_q;
	logic [OFFSET_W-1:0] phase_offsets_q;
	logic [MASK_W-1:0]   sync_mask_q;
	logic [SYNC_W-1:0]   sync_increment_q;

	logic [PHASE_BITS-1:0] phase_acc_q [NUM_OSC];
	logic [LEVEL_W-1:0]    held_random_q [NUM_OSC];
	logic [31:0]           noise_seed_q [NUM_OSC];

	state_t state_q, state_d;
	logic [OscW-1:0]      osc_q;
	logic [SAMPLE_W-1:0]  samples_q;
	logic signed [PROD_W-1:0] prod_q;
	logic [P_W-1:0]       p_q;
	logic signed [RAW_W-1:0] raw_q;
	logic                 out_valid_q;
	logic [LEVEL_W-1:0]   out_level_q;
	logic [INDEX_W-1:0]   out_index_q;
	logic                 out_last_q;

	logic in_ready, emit_go, is_last, mul_depth_sel;
	logic [INC_W-1:0]   inc;
	logic [OFF_W-1:0]   off;
	logic [DEPTH_W-1:0] depth;
	shape_t             shape;
	logic signed [RAW_W-1:0] mul_a;
	logic signed [MB_W-1:0]  mul_b;
	logic signed [PROD_W-1:0] mul_p;
	logic [PHASE_BITS-1:0] acc_next;
	logic [IdxProdW-1:0] idx_prod;
	logic [AddrW-1:0]    idx, rom_addr;
	logic [SINE_W-1:0]   rom_data;
	logic signed [RAW_W-1:0] sine_v, p_ext, raw_d;
	logic [31:0]         s1, s2, seed_next;
	logic                rand_hit;
	logic signed [PROD_W-1:0] rounded;
	logic signed [PROD_W-13:0] scaled;
	logic [LEVEL_W-1:0]  level_d;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rate_increments_q <= '0;
			depths_q          <= '0;
			shape_selects_q   <= '0;
			phase_offsets_q   <= '0;
			sync_mask_q       <= '0;
			sync_increment_q  <= '0;
		end else if (cfg_wr_en) begin
			case (cfg_addr)
				REG_RATE_INCREMENTS: rate_increments_q <= cfg_wdata[RATE_W-1:0];
				REG_DEPTHS:          depths_q          <= cfg_wdata[DEPTHS_W-1:0];
				REG_SHAPE_SELECTS:   shape_selects_q   <= cfg_wdata[SHAPES_W-1:0];
				REG_PHASE_OFFSETS:   phase_offsets_q   <= cfg_wdata[OFFSET_W-1:0];
				REG_SYNC_MASK:       sync_mask_q       <= cfg_wdata[MASK_W-1:0];
				REG_SYNC_INCREMENT:  sync_increment_q  <= cfg_wdata[SYNC_W-1:0];
				default: ;
			endcase
		end
	end

	assign inc   = sync_mask_q[osc_q] ? sync_increment_q : rate_increments_q[osc_q*INC_W +: INC_W];
	assign off   = phase_offsets_q[osc_q*OFF_W +: OFF_W];
	assign depth = depths_q[osc_q*DEPTH_W +: DEPTH_W];
	assign shape = shape_t'(shape_selects_q[osc_q*SHAPE_W +: SHAPE_W]);
	assign is_last = (osc_q == OscW'(NUM_OSC - 1));

	// Sequencer.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:      if (s_axis_tvalid) state_d = ST_MUL_INC;
			ST_MUL_INC:   state_d = ST_ACC;
			ST_ACC:       state_d = ST_PHASE;
			ST_PHASE:     state_d = ST_ROM;
			ST_ROM:       state_d = ST_RAW;
			ST_RAW:       state_d = ST_MUL_DEPTH;
			ST_MUL_DEPTH: state_d = ST_EMIT;
			ST_EMIT:      if (emit_go) state_d = is_last ? ST_IDLE : ST_MUL_INC;
			default:      state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready      = (state_q == ST_IDLE);
		mul_depth_sel = (state_q == ST_MUL_DEPTH);
		emit_go       = (state_q == ST_EMIT) && (!out_valid_q || m_axis_tready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			osc_q   <= '0;
		end else begin
			state_q <= state_d;
			if (in_ready) begin
				osc_q <= '0;
			end else if (emit_go && !is_last) begin
				osc_q <= osc_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && s_axis_tvalid) begin
			samples_q <= s_axis_tdata[SAMPLE_W-1:0];
		end
	end

	// Shared multiplier: increment times block length, then raw value times depth.
	assign mul_a = mul_depth_sel ? raw_q : RAW_W'(signed'({2'b00, inc}));
	assign mul_b = mul_depth_sel ? MB_W'(signed'({1'b0, depth})) : MB_W'(signed'({1'b0, samples_q}));
	assign mul_p = mul_a * mul_b;

	always_ff @(posedge clk) begin
		if (state_q == ST_MUL_INC || state_q == ST_MUL_DEPTH) begin
			prod_q <= mul_p;
		end
	end

	assign acc_next = phase_acc_q[osc_q] + PHASE_BITS'($unsigned(prod_q));

	always_ff @(posedge clk) begin
		if (state_q == ST_PHASE) begin
			p_q <= phase_acc_q[osc_q][PHASE_BITS-1 -: P_W] + off;
		end
	end

	// Quarter-wave table lookup.
	assign idx_prod = IdxProdW'(p_q[13:0]) * IdxProdW'(SINE_TABLE_DEPTH);
	assign idx      = idx_prod[IdxProdW-1:14];
	assign rom_addr = p_q[14] ? (AddrW'(SINE_TABLE_DEPTH) - idx) : idx;

	lfob_sine_rom #(
		.SINE_TABLE_DEPTH(SINE_TABLE_DEPTH),
		.ADDR_W(AddrW)
	) u_sine_rom (
		.clk (clk),
		.addr(rom_addr),
		.data(rom_data)
	);

	// Waveform shaping.
	assign s1        = noise_seed_q[osc_q] ^ (noise_seed_q[osc_q] << 13);
	assign s2        = s1 ^ (s1 >> 17);
	assign seed_next = s2 ^ (s2 << 5);
	assign rand_hit  = (p_q < RAND_WINDOW);
	assign sine_v    = RAW_W'(signed'({1'b0, rom_data}));
	assign p_ext     = RAW_W'(signed'({1'b0, p_q}));

	always_comb begin
		case (shape)
			SHAPE_SINE:     raw_d = p_q[15] ? -sine_v : sine_v;
			SHAPE_SQUARE:   raw_d = p_q[15] ? -18'sd32768 : 18'sd32768;
			SHAPE_TRIANGLE: raw_d = p_q[15] ? (18'sd98304 - (p_ext <<< 1))
			                                : ((p_ext <<< 1) - 18'sd32768);
			SHAPE_RAMPUP:   raw_d = p_ext - 18'sd32768;
			SHAPE_RAMPDOWN: raw_d = 18'sd32768 - p_ext;
			default: begin
				if (rand_hit) begin
					raw_d = RAW_W'(signed'({~seed_next[31], seed_next[30:16]}));
				end else begin
					raw_d = RAW_W'(signed'(held_random_q[osc_q]));
				end
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_RAW) begin
			raw_q <= raw_d;
		end
	end

	// Oscillator state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_OSC; i++) begin
				phase_acc_q[i]   <= '0;
				held_random_q[i] <= '0;
				noise_seed_q[i]  <= SEED_INIT[i];
			end
		end else begin
			if (state_q == ST_ACC) begin
				phase_acc_q[osc_q] <= acc_next;
			end
			if (state_q == ST_RAW && shape != SHAPE_SINE && shape != SHAPE_SQUARE &&
			    shape != SHAPE_TRIANGLE && shape != SHAPE_RAMPUP &&
			    shape != SHAPE_RAMPDOWN && rand_hit) begin
				noise_seed_q[osc_q]  <= seed_next;
				held_random_q[osc_q] <= {~seed_next[31], seed_next[30:16]};
			end
		end
	end

	// Rounding and saturation of the depth product.
	assign rounded = prod_q + PROD_W'(2048);
	assign scaled  = rounded[PROD_W-1:12];

	always_comb begin
		if (scaled > 20'sd32767) begin
			level_d = 16'h7FFF;
		end else if (scaled < -20'sd32768) begin
			level_d = 16'h8000;
		end else begin
			level_d = scaled[LEVEL_W-1:0];
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_go) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_go) begin
			out_level_q <= level_d;
			out_index_q <= INDEX_W'(osc_q);
			out_last_q  <= is_last;
		end
	end

	assign s_axis_tready = in_ready;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_level_q;
	assign m_axis_tuser  = out_index_q;
	assign m_axis_tlast  = out_last_q;

endmodule

// File: src/lfob_sine_rom.sv
module lfob_sine_rom #(
	parameter int SINE_TABLE_DEPTH = lfob_pkg::SINE_TABLE_DEPTH_DEF,
	parameter int ADDR_W = $clog2(SINE_TABLE_DEPTH + 1)
) (
	input  logic                       clk,
	input  logic [ADDR_W-1:0]          addr,
	output logic [lfob_pkg::SINE_W-1:0] data
);
	import lfob_pkg::*;

	localparam int RomDepth = SINE_TABLE_DEPTH + 1;
	localparam logic [63:0] SinA = 64'd1686557207;
	localparam logic [63:0] SinB = 64'd690662134;
	localparam logic [63:0] SinC = 64'd78071983;

	function automatic logic [SINE_W-1:0] rom_entry(input int k);
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] t;
		logic [63:0] u;
		logic [63:0] y;
		logic [63:0] q;
		x  = (64'(k) << 30) / SINE_TABLE_DEPTH;
		x2 = (x * x) >> 30;
		t  = SinB - ((x2 * SinC) >> 30);
		u  = SinA - ((x2 * t) >> 30);
		y  = (x * u) >> 30;
		q  = (y + 64'd16384) >> 15;
		if (q > 64'd32768) begin
			q = 64'd32768;
		end
		return SINE_W'(q);
	endfunction

	logic [SINE_W-1:0] rom_tbl [RomDepth];

	for (genvar k = 0; k < RomDepth; k++) begin : g_rom
		assign rom_tbl[k] = rom_entry(k);
	end

	logic [SINE_W-1:0] data_q;

	always_ff @(posedge clk) begin
		data_q <= rom_tbl[addr];
	end

	assign data = data_q;

endmodule

// File: src/lfob_checker.sv
module lfob_checker #(
	parameter int NUM_OSC = lfob_pkg::NUM_OSC_DEF
) (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            s_axis_tvalid,
	input logic                            s_axis_tready,
	input logic                            m_axis_tvalid,
	input logic                            m_axis_tready,
	input logic [15:0]                     m_axis_tdata,
	input logic [1:0]                      m_axis_tuser,
	input logic                            m_axis_tlast
);
	import lfob_pkg::*;

	// A word that is not taken stays on the bus unchanged.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
		&& $stable(m_axis_tuser) && $stable(m_axis_tlast))
		else $error("output word changed while stalled");

	// The block is busy right after it takes a block length.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("input ready right after an accepted word");

	// Only the highest oscillator closes a block.
	a_last_index: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tlast |-> m_axis_tuser == 2'(NUM_OSC - 1))
		else $error("tlast on a word that is not the last oscillator");

	// While a block is still being emitted no new block length is taken.
	a_no_input_mid_block: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tlast |-> !s_axis_tready)
		else $error("input ready in the middle of a block");

endmodule

bind lfo_bank_waveform_generator_top lfob_checker #(.NUM_OSC(NUM_OSC)) u_lfob_checker (.*);

// File: dv/tb_top.sv
module tb_top;
	import lfob_pkg::*;

	localparam int SINE_DEPTH      = 256;
	localparam int NOISE_WINDOW    = 66;
	localparam int RAND_PHASES     = 16;
	localparam int ITEMS_PER_PHASE = 30;
	localparam int STALL_LIMIT     = 3000;
	localparam int TAIL_CYCLES     = 64;

	localparam longint SIN_A = 1686557207;
	localparam longint SIN_B = 690662134;
	localparam longint SIN_C = 78071983;

	localparam logic [CFG_ADDR_W-1:0] REG_UNUSED_6 = 3'd6;
	localparam logic [CFG_ADDR_W-1:0] REG_UNUSED_7 = 3'd7;
	localparam logic [SHAPE_W-1:0] SHAPE_ALIAS_6 = 3'd6;
	localparam logic [SHAPE_W-1:0] SHAPE_ALIAS_7 = 3'd7;

	typedef struct packed {
		logic [1:0]  osc;
		logic [15:0] level;
		logic        last;
	} osc_word_t;

	typedef struct packed {
		logic                  wr;
		logic [CFG_ADDR_W-1:0] addr;
		logic [63:0]           data;
		logic                  send;
		logic [12:0]           samples;
		logic                  pin;
		logic [15:0]           level;
	} stim_row_t;

	// When pin is set, every oscillator of that block is expected to give level.
	localparam int DIR_ROWS = 33;
	localparam stim_row_t DIRECTED [DIR_ROWS] = '{
		'{1'b0, REG_RATE_INCREMENTS, 64'd0, 1'b1, 13'd1, 1'b1, 16'h0000},
		'{1'b0, REG_RATE_INCREMENTS, 64'd0, 1'b1, 13'd8191, 1'b1, 16'h0000},
		'{1'b1, REG_DEPTHS, {12'd0, {4{13'd4096}}}, 1'b0, 13'd0, 1'b0, 16'h0000},
		'{1'b1, REG_SHAPE_SELECTS, {52'd0, {4{SHAPE_SQUARE}}}, 1'b0, 13'd0, 1'b0, 16'h0000},
		'{1'b0, REG_RATE_INCREMENTS, 64'd0, 1'b1, 13'd1, 1'b1, 16'h7FFF},
		'{1'b1, REG_PHASE_OFFSETS, 64'h8000_8000_8000_8000, 1'b0, 13'd0, 1'b0, 16'h0000},
		'{1'b0, REG_RATE_INCREMENTS, 64'd0, 1'b1, 13'd4096, 1'b1, 16'h8000},
		'{1'b1, REG_DEPTHS, {12'd0, {4{13'h1FFF}}}, 1'b0, 13'd0, 1'b0, 16'h0000},
		'{1'b0, REG_RATE_INCREMENTS, 64'd0, 1'b1, 13'd0, 1'b1, 16'h8000},
		'{1'b1, REG_PHASE_OFFSETS, 64'h0000_0041_0042_0000, 1'b0, 13'd0, 1'b0, 16'h0000},
		'{1'b1, REG_SHAPE_SELECTS,
			{52'd0, SHAPE_ALIAS_7, SHAPE_ALIAS_6, SHAPE_RANDOM, SHAPE_RAMPDOWN},
			1'b0, 13'd0, 1'b0, 16'h0000},
		'{1'b0, REG_RATE_INCREMENTS, 64'd0, 1'b1, 13'd1, 1'b0, 16'h0000},
		'{1'b0, REG_RATE_INCREMENTS, 64'd0, 1'b1, 13'd1, 1'b0, 16'h0000},
		'{1'b0, REG_RATE_INCREMENTS, 64'd0, 1'b1, 13'd8191, 1'b0, 16'h0000},
		'{1'b1, REG_RATE_INCREMENTS, 64'hFFFF_8000_0101_0001, 1'b0, 13'd0, 1'b0, 16'h0000},
		'{1'b1, REG_SHAPE_SELECTS,
			{52'd0, SHAPE_RAMPUP, SHAPE_TRIANGLE, SHAPE_SQUARE, SHAPE_SINE},
			1'b0, 13'd0, 1'b0, 16'h0000},
		'{1'b1, REG_DEPTHS, {12'd0, 13'd1, 13'h1FFF, 13'd2048, 13'd4096},
			1'b0, 13'd0, 1'b0, 16'h0000},
		'{1'b1, REG_PHASE_OFFSETS, 64'h0000_FFFF_4000_C000, 1'b0, 13'd0, 1'b0, 16'h0000},
		'{1'b0, REG_RATE_INCREMENTS, 64'd0, 1'b1, 13'd4096, 1'b0, 16'h0000},
		'{1'b0, REG_RATE_INCREMENTS, 64'd0, 1'b1, 13'd4095, 1'b0, 16'h0000},
		'{1'b0, REG_RATE_INCREMENTS, 64'd0, 1'b1, 13'd1, 1'b0, 16'h0000},
		'{1'b0, REG_RATE_INCREMENTS, 64'd0, 1'b1, 13'h0AAA, 1'b0, 16'h0000},
		'{1'b0, REG_RATE_INCREMENTS, 64'd0, 1'b1, 13'h1555, 1'b0, 16'h0000},
		'{1'b1, REG_SYNC_INCREMENT, 64'h0000_0000_0000_FFFF, 1'b0, 13'd0, 1'b0, 16'h0000},
		'{1'b1, REG_SYNC_MASK, 64'h0000_0000_0000_000F, 1'b0, 13'd0, 1'b0, 16'h0000},
		'{1'b0, REG_RATE_INCREMENTS, 64'd0, 1'b1, 13'd4096, 1'b0, 16'h0000},
		'{1'b0, REG_RATE_INCREMENTS, 64'd0, 1'b1, 13'd77, 1'b0, 16'h0000},
		'{1'b1, REG_SYNC_INCREMENT, 64'h0000_0000_0000_0001, 1'b0, 13'd0, 1'b0, 16'h0000},
		'{1'b1, REG_SYNC_MASK, 64'h0000_0000_0000_0005, 1'b0, 13'd0, 1'b0, 16'h0000},
		'{1'b1, REG_UNUSED_6, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 13'd0, 1'b0, 16'h0000},
		'{1'b1, REG_UNUSED_7, 64'hA5A5_5A5A_A5A5_5A5A, 1'b0, 13'd0, 1'b0, 16'h0000},
		'{1'b0, REG_RATE_INCREMENTS, 64'd0, 1'b1, 13'd333, 1'b0, 16'h0000},
		'{1'b0, REG_RATE_INCREMENTS, 64'd0, 1'b1, 13'd4096, 1'b0, 16'h0000}
	};

	logic                  clk           = 1'b0;
	logic                  arst_n        = 1'b0;
	logic                  cfg_wr_en     = 1'b0;
	logic [CFG_ADDR_W-1:0] cfg_addr      = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata     = '0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [15:0]           s_axis_tdata  = '0;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [15:0]           m_axis_tdata;
	logic [1:0]            m_axis_tuser;
	logic                  m_axis_tlast;

	logic [63:0] rate_cfg      = '0;
	logic [51:0] depth_cfg     = '0;
	logic [11:0] shape_cfg     = '0;
	logic [63:0] offset_cfg    = '0;
	logic [3:0]  sync_mask_cfg = '0;
	logic [15:0] sync_inc_cfg  = '0;

	logic [23:0] osc_phase [4]   = '{24'd0, 24'd0, 24'd0, 24'd0};
	int          held_rand [4]   = '{0, 0, 0, 0};
	logic [31:0] noise_state [4] = '{32'h12345678, 32'h9E3779B9, 32'h2545F491, 32'h6C8E9CF5};

	osc_word_t   pending_levels [$];
	osc_word_t   head_word;
	int          mismatches    = 0;
	int          blocks_sent   = 0;
	int          words_checked = 0;
	int          quiet_cycles  = 0;
	int unsigned rx_hold       = 0;
	bit          tx_calm       = 1'b0;
	bit          rx_calm       = 1'b0;

	lfo_bank_waveform_generator_top dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_addr      (cfg_addr),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int unsigned pick_gap(input bit calm);
		int unsigned roll;
		roll = $urandom_range(99);
		if (calm || roll < 55)
			return 0;
		if (roll < 90)
			return $urandom_range(3, 1);
		if (roll < 98)
			return $urandom_range(12, 4);
		return $urandom_range(60, 13);
	endfunction

	// Advances every oscillator by one audio block and queues the levels it must produce.
	task automatic advance_bank(input logic [12:0] n, input bit pin, input logic [15:0] pinned);
		logic [15:0] inc;
		logic [15:0] off;
		logic [2:0]  shp;
		logic [12:0] dep;
		logic [23:0] shaped;
		logic [15:0] p;
		logic [31:0] s;
		int          idx;
		longint      x, x2, t, u, y, q;
		int          raw;
		int          lvl;
		osc_word_t   w;
		for (int i = 0; i < 4; i++) begin
			inc = sync_mask_cfg[i] ? sync_inc_cfg : rate_cfg[16*i +: 16];
			off = offset_cfg[16*i +: 16];
			shp = shape_cfg[3*i +: 3];
			dep = depth_cfg[13*i +: 13];
			osc_phase[i] = osc_phase[i] + 24'(32'(inc) * 32'(n));
			shaped = osc_phase[i] + {off, 8'h00};
			p = shaped[23:8];
			case (shp)
			SHAPE_SINE: begin
				idx = (int'(p[13:0]) * SINE_DEPTH) >> 14;
				if (p[14])
					idx = SINE_DEPTH - idx;
				x = (longint'(idx) << 30) / SINE_DEPTH;
				x2 = (x * x) >>> 30;
				t = SIN_B - ((x2 * SIN_C) >>> 30);
				u = SIN_A - ((x2 * t) >>> 30);
				y = (x * u) >>> 30;
				q = (y + 16384) >>> 15;
				if (q > 32768)
					q = 32768;
				raw = p[15] ? -int'(q) : int'(q);
			end
			SHAPE_SQUARE:   raw = p[15] ? -32768 : 32768;
			SHAPE_TRIANGLE: raw = p[15] ? 98304 - 2 * int'(p) : 2 * int'(p) - 32768;
			SHAPE_RAMPUP:   raw = int'(p) - 32768;
			SHAPE_RAMPDOWN: raw = 32768 - int'(p);
			default: begin
				if (p < NOISE_WINDOW) begin
					s = noise_state[i];
					s ^= s << 13;
					s ^= s >> 17;
					s ^= s << 5;
					noise_state[i] = s;
					held_rand[i] = int'(s[31:16]) - 32768;
				end
				raw = held_rand[i];
			end
			endcase
			lvl = (raw * int'(dep) + 2048) >>> 12;
			if (lvl > 32767)
				lvl = 32767;
			else if (lvl < -32768)
				lvl = -32768;
			w.osc = 2'(i);
			w.level = pin ? pinned : 16'(lvl);
			w.last = (i == 3);
			pending_levels.push_back(w);
		end
	endtask

	task automatic send_block(input logic [12:0] n);
		int unsigned gap;
		gap = pick_gap(tx_calm);
		if (gap != 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {3'b000, n};
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		blocks_sent++;
	endtask

	task automatic settle_bank();
		s_axis_tvalid <= 1'b0;
		while (pending_levels.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_setting(input logic [CFG_ADDR_W-1:0] addr, input logic [63:0] value);
		settle_bank();
		cfg_wr_en <= 1'b1;
		cfg_addr <= addr;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		case (addr)
		REG_RATE_INCREMENTS: rate_cfg = value;
		REG_DEPTHS:          depth_cfg = value[51:0];
		REG_SHAPE_SELECTS:   shape_cfg = value[11:0];
		REG_PHASE_OFFSETS:   offset_cfg = value;
		REG_SYNC_MASK:       sync_mask_cfg = value[3:0];
		REG_SYNC_INCREMENT:  sync_inc_cfg = value[15:0];
		default: ;
		endcase
	endtask

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			words_checked++;
			if (pending_levels.size() == 0) begin
				mismatches++;
				$display("%0t: unexpected word: osc %0d level %0d last %0b", $time,
					m_axis_tuser, $signed(m_axis_tdata), m_axis_tlast);
			end else begin
				head_word = pending_levels.pop_front();
				if (m_axis_tdata !== head_word.level || m_axis_tuser !== head_word.osc ||
						m_axis_tlast !== head_word.last) begin
					mismatches++;
					$display("%0t: expected osc %0d level %0d last %0b, got osc %0d level %0d last %0b",
						$time, head_word.osc, $signed(head_word.level), head_word.last,
						m_axis_tuser, $signed(m_axis_tdata), m_axis_tlast);
				end
			end
		end
		if (rx_hold != 0) begin
			rx_hold--;
			m_axis_tready <= 1'b0;
		end else begin
			rx_hold = pick_gap(rx_calm);
			m_axis_tready <= (rx_hold == 0);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_wr_en)
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("%0t: no handshake for %0d cycles, %0d words still awaited", $time,
					quiet_cycles, pending_levels.size());
				$display("*** FAILED ***");
				$finish;
			end
		end
	end

	initial begin
		logic [63:0] rates;
		logic [63:0] offs;
		logic [51:0] deps;
		logic [11:0] shapes;
		logic [3:0]  mask;
		logic [15:0] sinc;
		bit          corner;
		logic [12:0] n_samples;
		int unsigned roll;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		for (int r = 0; r < DIR_ROWS; r++) begin
			if (DIRECTED[r].wr)
				write_setting(DIRECTED[r].addr, DIRECTED[r].data);
			if (DIRECTED[r].send) begin
				send_block(DIRECTED[r].samples);
				advance_bank(DIRECTED[r].samples, DIRECTED[r].pin, DIRECTED[r].level);
			end
		end

		for (int ph = 0; ph < RAND_PHASES; ph++) begin
			tx_calm = ($urandom_range(3) == 0);
			rx_calm = ($urandom_range(3) == 0);
			corner = (ph % 4 == 0);
			mask = 4'($urandom_range(15));
			sinc = corner ? ($urandom_range(1) ? 16'hFFFF : 16'h0000) : 16'($urandom);
			for (int i = 0; i < 4; i++) begin
				shapes[3*i +: 3] = 3'($urandom_range(7));
				if (corner) begin
					rates[16*i +: 16] = $urandom_range(1) ? 16'hFFFF : 16'h0000;
					offs[16*i +: 16] = $urandom_range(1) ? 16'hFFFF : 16'h0000;
					case ($urandom_range(2))
					0:       deps[13*i +: 13] = 13'd0;
					1:       deps[13*i +: 13] = 13'd4096;
					default: deps[13*i +: 13] = 13'h1FFF;
					endcase
				end else begin
					rates[16*i +: 16] = $urandom_range(1) ? 16'($urandom) : 16'($urandom_range(255));
					offs[16*i +: 16] = 16'($urandom);
					deps[13*i +: 13] = 13'($urandom_range(8191));
				end
				// A frozen phase parked at or just past the start of the cycle keeps the sample-and-hold
				// generator stepping on every block when it lands inside NOISE_WINDOW; past it the level holds.
				if (shapes[3*i +: 3] >= SHAPE_RANDOM && $urandom_range(1)) begin
					rates[16*i +: 16] = 16'h0000;
					mask[i] = 1'b0;
					offs[16*i +: 16] = 16'($urandom_range(70)) - osc_phase[i][23:8];
				end
			end
			write_setting(REG_RATE_INCREMENTS, rates);
			write_setting(REG_DEPTHS, {12'd0, deps});
			write_setting(REG_SHAPE_SELECTS, {52'd0, shapes});
			write_setting(REG_PHASE_OFFSETS, offs);
			write_setting(REG_SYNC_MASK, {60'd0, mask});
			write_setting(REG_SYNC_INCREMENT, {48'd0, sinc});
			if ($urandom_range(3) == 0)
				write_setting(REG_UNUSED_7, {$urandom, $urandom});
			for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
				roll = $urandom_range(99);
				if (roll < 8)
					n_samples = 13'($urandom_range(8191));
				else if (roll < 30)
					n_samples = 13'($urandom_range(16, 1));
				else
					n_samples = 13'($urandom_range(4096, 1));
				send_block(n_samples);
				advance_bank(n_samples, 1'b0, 16'h0000);
			end
		end

		settle_bank();
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Sent %0d audio blocks over the directed settings and %0d random register sets.",
			blocks_sent, RAND_PHASES);
		$display("Checked %0d oscillator words, %0d mismatches.", words_checked, mismatches);
		if (mismatches == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
